FILE: src/mes_pkg.sv
package mes_pkg;

    localparam int COORD_BITS  = 12;
    localparam int RADIUS_BITS = 10;

    localparam int OUT_W  = COORD_BITS + 1;
    localparam int PX_W   = RADIUS_BITS + 1;
    localparam int PY_W   = RADIUS_BITS + 2;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int GRAD_W = 3 * RADIUS_BITS + 4;
    localparam int DEC_W  = 4 * RADIUS_BITS + 10;
    localparam int MUL_W  = 2 * RADIUS_BITS + 4;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = COORD_BITS + RADIUS_BITS + 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_PROD,
        ST_INIT,
        ST_TX,
        ST_TXR,
        ST_TY,
        ST_TYR,
        ST_RR,
        ST_R2,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        REG_IDLE,
        REG_ONE,
        REG_TWO,
        REG_DONE
    } region_t;

    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_RXRX,
        MOP_RYRY,
        MOP_RX2RY,
        MOP_TXTX,
        MOP_RY2P,
        MOP_TYTY,
        MOP_RX2P,
        MOP_RX2RY2
    } mop_t;

    typedef struct packed {
        logic       start;
        logic       step;
        mop_t       mop;
        logic       wr_rx2;
        logic       wr_ry2;
        logic       init;
        logic       acc_load;
        logic       acc_add;
        logic       set_r2;
        logic [1:0] emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic prod_zero;
        logic to_r2;
    } dp_stat_t;

endpackage

FILE: src/mes_ctrl.sv
module mes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    output logic              out_valid,
    input  logic              out_stall,
    input  mes_pkg::dp_stat_t stat,
    output mes_pkg::dp_cmd_t  cmd
);
    import mes_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       pend_reg, pend_next;
    logic       take_start, take_step;

    assign take_start = (state_reg == ST_IDLE) && in_valid && !op;
    assign take_step  = (state_reg == ST_IDLE) && in_valid && op && stat.active;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_start)
                begin
                    state_next = ST_SQX;
                    pend_next  = 1'b0;
                end
                else if (take_step)
                begin
                    pend_next  = 1'b1;
                    state_next = stat.to_r2 ? ST_TX : ST_EMIT;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_PROD;
            ST_PROD: state_next = ST_INIT;
            // a zero radius leaves both gradients at zero: region 2 at once
            ST_INIT: state_next = stat.prod_zero ? ST_TX : ST_IDLE;
            ST_TX:   state_next = ST_TXR;
            ST_TXR:  state_next = ST_TY;
            ST_TY:   state_next = ST_TYR;
            ST_TYR:  state_next = ST_RR;
            ST_RR:   state_next = ST_R2;
            ST_R2:   state_next = pend_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mop      = MOP_NONE;
        cmd.emit_idx = k_reg;
        cmd.start    = take_start;
        cmd.step     = take_step;
        in_stall     = (state_reg != ST_IDLE);
        out_valid    = (state_reg == ST_EMIT);
        case (state_reg)
            ST_SQX:  cmd.mop = MOP_RXRX;
            ST_SQY:
            begin
                cmd.mop    = MOP_RYRY;
                cmd.wr_rx2 = 1'b1;
            end
            ST_PROD:
            begin
                cmd.mop    = MOP_RX2RY;
                cmd.wr_ry2 = 1'b1;
            end
            ST_INIT: cmd.init = 1'b1;
            ST_TX:   cmd.mop  = MOP_TXTX;
            ST_TXR:  cmd.mop  = MOP_RY2P;
            ST_TY:
            begin
                cmd.mop      = MOP_TYTY;
                cmd.acc_load = 1'b1;
            end
            ST_TYR:  cmd.mop = MOP_RX2P;
            ST_RR:
            begin
                cmd.mop     = MOP_RX2RY2;
                cmd.acc_add = 1'b1;
            end
            ST_R2:   cmd.set_r2 = 1'b1;
            default: cmd.mop = MOP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: src/mes_datapath.sv
module mes_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mes_pkg::dp_cmd_t                      cmd,
    output mes_pkg::dp_stat_t                     stat,
    input  logic signed [mes_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [mes_pkg::COORD_BITS-1:0] center_y,
    input  logic [mes_pkg::RADIUS_BITS-1:0]       radius_x,
    input  logic [mes_pkg::RADIUS_BITS-1:0]       radius_y,
    input  logic [7:0]                            symbol,
    output logic signed [mes_pkg::OUT_W-1:0]      point_x,
    output logic signed [mes_pkg::OUT_W-1:0]      point_y,
    output logic [7:0]                            glyph,
    output logic                                  last_of_step,
    output logic                                  done_res
);
    import mes_pkg::*;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [RADIUS_BITS-1:0]       rx_reg, ry_reg;
    logic [7:0]                   sym_reg;
    logic [SQ_W-1:0]              rx2_reg, ry2_reg;
    logic [PX_W-1:0]              px_reg, px_next, bx_reg;
    logic signed [PY_W-1:0]       py_reg, py_next, by_reg;
    logic signed [GRAD_W-1:0]     gx_reg, gx_next, gy_reg, gy_next;
    logic signed [DEC_W-1:0]      dec_reg, dec_next, acc_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    region_t                      region_reg, region_next;
    logic                         fin_reg, fin_next;

    logic signed [GRAD_W-1:0] rx2_g, ry2_g, gx_inc, gy_dec;
    logic signed [DEC_W-1:0]  rx2_d, ry2_d, gx_inc_d, gy_dec_d, prod_d;
    logic signed [MUL_W-1:0]  ma, mb;
    logic [PX_W:0]            tx;
    logic signed [PY_W:0]     ty;
    logic signed [SUM_W-1:0]  cx_s, cy_s, bx_s, by_s, sum_x, sum_y;

    assign rx2_g    = $signed({{(GRAD_W-SQ_W){1'b0}}, rx2_reg});
    assign ry2_g    = $signed({{(GRAD_W-SQ_W){1'b0}}, ry2_reg});
    assign rx2_d    = $signed({{(DEC_W-SQ_W){1'b0}}, rx2_reg});
    assign ry2_d    = $signed({{(DEC_W-SQ_W){1'b0}}, ry2_reg});
    assign gx_inc   = gx_reg + (ry2_g <<< 1);
    assign gy_dec   = gy_reg - (rx2_g <<< 1);
    assign gx_inc_d = {{(DEC_W-GRAD_W){gx_inc[GRAD_W-1]}}, gx_inc};
    assign gy_dec_d = {{(DEC_W-GRAD_W){gy_dec[GRAD_W-1]}}, gy_dec};
    assign prod_d   = {{(DEC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // one midpoint step on the current position
    always_comb
    begin
        px_next = px_reg;
        py_next = py_reg;
        gx_next = gx_reg;
        gy_next = gy_reg;
        if (region_reg == REG_ONE)
        begin
            px_next = px_reg + PX_W'(1);
            gx_next = gx_inc;
            if (dec_reg < 0)
            begin
                dec_next = dec_reg + ((gx_inc_d + ry2_d) <<< 2);
            end
            else
            begin
                py_next  = py_reg - PY_W'(1);
                gy_next  = gy_dec;
                dec_next = dec_reg + ((gx_inc_d - gy_dec_d + ry2_d) <<< 2);
            end
        end
        else
        begin
            py_next = py_reg - PY_W'(1);
            gy_next = gy_dec;
            if (dec_reg > 0)
            begin
                dec_next = dec_reg + ((rx2_d - gy_dec_d) <<< 2);
            end
            else
            begin
                px_next  = px_reg + PX_W'(1);
                gx_next  = gx_inc;
                dec_next = dec_reg + ((gx_inc_d - gy_dec_d + rx2_d) <<< 2);
            end
        end
    end

    assign stat.active    = (region_reg == REG_ONE) || (region_reg == REG_TWO);
    assign stat.prod_zero = (prod_reg == '0);
    assign stat.to_r2     = (region_reg == REG_ONE) && !(gx_next < gy_next);

    always_comb
    begin
        region_next = region_reg;
        fin_next    = fin_reg;
        if (cmd.start)
        begin
            fin_next = 1'b0;
        end
        else if (cmd.step)
        begin
            fin_next = (region_reg == REG_TWO) && py_next[PY_W-1];
            if (fin_next)
            begin
                region_next = REG_DONE;
            end
        end
        else if (cmd.init)
        begin
            region_next = REG_ONE;
        end
        else if (cmd.set_r2)
        begin
            if (py_reg[PY_W-1])
            begin
                region_next = REG_DONE;
                fin_next    = 1'b1;
            end
            else
            begin
                region_next = REG_TWO;
            end
        end
    end

    assign tx = {px_reg, 1'b1};
    assign ty = {py_reg[PY_W-1], py_reg} - (PY_W+1)'(1);

    always_comb
    begin
        case (cmd.mop)
            MOP_RXRX:
            begin
                ma = $signed(MUL_W'(rx_reg));
                mb = $signed(MUL_W'(rx_reg));
            end
            MOP_RYRY:
            begin
                ma = $signed(MUL_W'(ry_reg));
                mb = $signed(MUL_W'(ry_reg));
            end
            MOP_RX2RY:
            begin
                ma = $signed(MUL_W'(rx2_reg));
                mb = $signed(MUL_W'(ry_reg));
            end
            MOP_TXTX:
            begin
                ma = $signed(MUL_W'(tx));
                mb = $signed(MUL_W'(tx));
            end
            MOP_RY2P:
            begin
                ma = $signed(MUL_W'(ry2_reg));
                mb = prod_reg[MUL_W-1:0];
            end
            MOP_TYTY:
            begin
                ma = MUL_W'(ty);
                mb = MUL_W'(ty);
            end
            MOP_RX2P:
            begin
                ma = $signed(MUL_W'(rx2_reg));
                mb = prod_reg[MUL_W-1:0];
            end
            MOP_RX2RY2:
            begin
                ma = $signed(MUL_W'(rx2_reg));
                mb = $signed(MUL_W'(ry2_reg));
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= REG_IDLE;
            fin_reg    <= 1'b0;
        end
        else
        begin
            region_reg <= region_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mop != MOP_NONE)
        begin
            prod_reg <= ma * mb;
        end
        if (cmd.wr_rx2)
        begin
            rx2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.wr_ry2)
        begin
            ry2_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.start)
        begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            rx_reg  <= radius_x;
            ry_reg  <= radius_y;
            sym_reg <= symbol;
            px_reg  <= '0;
            py_reg  <= $signed(PY_W'(radius_y));
            gx_reg  <= '0;
        end
        else if (cmd.step)
        begin
            // hold the old position for the four points of this item
            bx_reg  <= px_reg;
            by_reg  <= py_reg;
            px_reg  <= px_next;
            py_reg  <= py_next;
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            dec_reg <= dec_next;
        end
        else if (cmd.init)
        begin
            gy_reg  <= {prod_reg[GRAD_W-2:0], 1'b0};
            dec_reg <= (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
        end
        else if (cmd.set_r2)
        begin
            dec_reg <= acc_reg - (prod_d <<< 2);
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_d;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + (prod_d <<< 2);
        end
    end

    assign cx_s  = SUM_W'(cx_reg);
    assign cy_s  = SUM_W'(cy_reg);
    assign bx_s  = $signed(SUM_W'(bx_reg));
    assign by_s  = SUM_W'(by_reg);
    assign sum_x = cmd.emit_idx[0] ? (cx_s - bx_s) : (cx_s + bx_s);
    assign sum_y = cmd.emit_idx[1] ? (cy_s - by_s) : (cy_s + by_s);

    assign point_x      = sum_x[OUT_W-1:0];
    assign point_y      = sum_y[OUT_W-1:0];
    assign glyph        = sym_reg;
    assign last_of_step = (cmd.emit_idx == 2'd3);
    assign done_res     = (cmd.emit_idx == 2'd3) && fin_reg;

endmodule

FILE: src/midpoint_ellipse_stepper_top.sv
// Midpoint ellipse stepper.
// Input channel (in_valid / in_stall): op 0 starts an ellipse from center_x,
// center_y, radius_x, radius_y and symbol; op 1 advances one step. An item
// is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): each step item gives four points,
// (+x,+y), (-x,+y), (+x,-y), (-x,-y), with last_of_step on the fourth and
// done_res on the fourth point of the final step. A step when no ellipse is
// active gives nothing. A start gives nothing and drops any ellipse in hand.
// A step is accepted, then gives one point a cycle while the receiver takes
// them; one that carries the change to region 2 first builds the decision
// value in ST_TX, ST_TXR, ST_TY, ST_TYR, ST_RR and ST_R2, the first five on
// the single shared multiplier. Receiver stalls lengthen a step. A start
// runs three multiplies and set-up, plus the region 2 build for a zero radius.
// The next item is taken only once the previous one is finished.
// While out_stall is high the current point holds and nothing new is taken.
// Reset (rst_n low, asynchronous) leaves the block idle with no ellipse.
module midpoint_ellipse_stepper_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic signed [mes_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [mes_pkg::COORD_BITS-1:0] center_y,
    input  logic [mes_pkg::RADIUS_BITS-1:0]       radius_x,
    input  logic [mes_pkg::RADIUS_BITS-1:0]       radius_y,
    input  logic [7:0]                            symbol,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [mes_pkg::OUT_W-1:0]      point_x,
    output logic signed [mes_pkg::OUT_W-1:0]      point_y,
    output logic [7:0]                            glyph,
    output logic                                  last_of_step,
    output logic                                  done_res
);
    import mes_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mes_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .symbol       (symbol),
        .point_x      (point_x),
        .point_y      (point_y),
        .glyph        (glyph),
        .last_of_step (last_of_step),
        .done_res     (done_res)
    );

endmodule
